### hdl/jch_pkg.sv
// ----------------------------------------------------------------------------
// jch_pkg - jump consistent hash shared constants
// Widths of the key and count register, the LCG multiplier split into
// 32-bit halves, and the fixed shift amounts of the hash round.
// ----------------------------------------------------------------------------
`default_nettype none

package jch_pkg;

  localparam int KEY_W       = 64;
  localparam int HALF_W      = 32;
  localparam int CFG_W       = 17;
  localparam int KEY_SHIFT   = 33;
  localparam int SCALE_SHIFT = 31;
  localparam int DIVISOR_W   = 32;

  // 2862933555777941757 = 0x27BB2EE687B0B0FD
  localparam logic [HALF_W-1:0] LCG_MULT_LO = 32'h87B0_B0FD;
  localparam logic [HALF_W-1:0] LCG_MULT_HI = 32'h27BB_2EE6;

  localparam logic [CFG_W-1:0] COUNT_RESET = 17'd1024;

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [DIVISOR_W-1:0] divisor_t;

endpackage

`default_nettype wire

### hdl/jch_lcg.sv
// ----------------------------------------------------------------------------
// jch_lcg - LCG key advance on one shared 32x32 multiplier
// Computes key*MULT+1 mod 2^64 as three 32x32 partial products issued in
// consecutive cycles, each product registered before it is accumulated.
// ----------------------------------------------------------------------------
`default_nettype none

module jch_lcg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire jch_pkg::key_t key_i,
  input  wire logic         start,
  output logic              done,
  output jch_pkg::key_t     key_o
);
  import jch_pkg::*;

  logic                busy_r, busy_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  key_t                k_r, k_nxt;
  key_t                acc_r, acc_nxt;
  logic [2*HALF_W-1:0] prod_r, prod_nxt;
  logic [HALF_W-1:0]   op_a, op_b;

  // Pick the partial product for this step
  always_comb begin
    case (cnt_r)
      2'd0:    begin op_a = k_r[HALF_W-1:0];     op_b = LCG_MULT_LO; end
      2'd1:    begin op_a = k_r[KEY_W-1:HALF_W]; op_b = LCG_MULT_LO; end
      default: begin op_a = k_r[HALF_W-1:0];     op_b = LCG_MULT_HI; end
    endcase
  end

  // Issue products in steps 0..2, accumulate them in steps 1..3
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    if (load) begin
      k_nxt = key_i;
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      acc_nxt  = key_t'(1);
    end else if (busy_r) begin
      if (cnt_r != 2'd3) begin
        prod_nxt = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
      end
      if (cnt_r == 2'd1) begin
        acc_nxt = acc_r + prod_r;
      end else if (cnt_r != 2'd0) begin
        acc_nxt[KEY_W-1:HALF_W] = acc_r[KEY_W-1:HALF_W] + prod_r[HALF_W-1:0];
      end
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        k_nxt    = acc_nxt;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign done  = done_r;
  assign key_o = k_r;

endmodule

`default_nettype wire

### hdl/jch_div.sv
// ----------------------------------------------------------------------------
// jch_div - restoring divider, one quotient bit per cycle
// Divides (numer_hi << 31) by a divisor of at most 2^31 and returns the
// exact full-width quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module jch_div #(
  parameter int BUCKET_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [BUCKET_BITS:0]                  numer_hi,
  input  wire jch_pkg::divisor_t                     divisor,
  output logic                                       done,
  output logic [BUCKET_BITS+jch_pkg::DIVISOR_W-1:0]  quot
);
  import jch_pkg::*;

  localparam int QW    = BUCKET_BITS + DIVISOR_W;
  localparam int CNT_W = $clog2(QW);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [QW-1:0]        dq_r, dq_nxt;
  divisor_t             rem_r, rem_nxt;
  divisor_t             dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, dq_r[QW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = {numer_hi, {SCALE_SHIFT{1'b0}}};
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (diff[DIVISOR_W]) begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end else begin
        rem_nxt = diff[DIVISOR_W-1:0];
      end
      dq_nxt = {dq_r[QW-2:0], ~diff[DIVISOR_W]};
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

`default_nettype wire

### hdl/jump_consistent_hash.sv
// ----------------------------------------------------------------------------
// jump_consistent_hash - key to bucket mapper
// Sequencer around a shared-multiplier LCG and a bit-serial divider that
// runs the jump consistent hash rounds for one key at a time.
// ----------------------------------------------------------------------------
//  port group  dir  tdata / data fields (low bit up)
//  in_*        in   tdata[63:0] key
//  out_*       out  tdata[BUCKET_BITS-1:0] bucket, upper bits zero
//  cfg_*       in   wdata[16:0] bucket_count, written when cfg_we is high
//
//  One round runs the four steps of the LCG multiplier (the last one raising
//  done) and then the bit-serial divider.
//  A key needs about ln(bucket_count)+1 rounds, at most bucket_count; the
//  result then waits in ST_OUT until the output register is free, and the
//  next key is taken once the sequencer is back in ST_IDLE.
//  in_tready is high only while no key is in work; a held result does not
//  block the next key. Reset sets bucket_count to 1024 and empties output.
// ----------------------------------------------------------------------------
`default_nettype none

module jump_consistent_hash #(
  parameter int BUCKET_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // key
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire jch_pkg::key_t                       in_tdata,
  // bucket
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((BUCKET_BITS+7)/8)*8-1:0]         out_tdata,
  // bucket_count
  input  wire logic                                cfg_we,
  input  wire logic [jch_pkg::CFG_W-1:0]           cfg_wdata
);
  import jch_pkg::*;

  localparam int OUT_W = ((BUCKET_BITS + 7) / 8) * 8;
  localparam int QW    = BUCKET_BITS + DIVISOR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LCG  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CFG_W-1:0]       cfg_r, cfg_nxt;
  logic [BUCKET_BITS:0]   count_r, count_nxt;
  logic [BUCKET_BITS-1:0] b_r, b_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [BUCKET_BITS-1:0] obucket_r, obucket_nxt;

  logic                   accept;
  logic                   lcg_start, lcg_done;
  key_t                   lcg_key;
  logic                   div_done;
  divisor_t               divisor;
  logic [QW-1:0]          quot;
  logic                   j_below;
  logic [31:0]            cfg_ext, limit, eff32;
  logic [BUCKET_BITS:0]   eff;

  // Clamp the programmed count to 1 .. 2^BUCKET_BITS
  always_comb begin
    cfg_ext = 32'(cfg_r);
    limit   = 32'd1 << BUCKET_BITS;
    if (cfg_ext == 32'd0) begin
      eff32 = 32'd1;
    end else if (cfg_ext > limit) begin
      eff32 = limit;
    end else begin
      eff32 = cfg_ext;
    end
    eff = eff32[BUCKET_BITS:0];
  end

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign divisor   = DIVISOR_W'(lcg_key[KEY_W-1:KEY_SHIFT]) + divisor_t'(1);
  assign j_below   = quot < QW'(count_r);
  assign lcg_start = accept || (state_r == ST_DIV && div_done && j_below);

  jch_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .key_i (in_tdata),
    .start (lcg_start),
    .done  (lcg_done),
    .key_o (lcg_key)
  );

  jch_div #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (lcg_done),
    .numer_hi ({1'b0, b_r} + {{BUCKET_BITS{1'b0}}, 1'b1}),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // Round sequencer and output register
  always_comb begin
    state_nxt   = state_r;
    cfg_nxt     = cfg_r;
    count_nxt   = count_r;
    b_nxt       = b_r;
    ovalid_nxt  = ovalid_r;
    obucket_nxt = obucket_r;
    if (cfg_we) begin
      cfg_nxt = cfg_wdata;
    end
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          b_nxt     = '0;
          count_nxt = eff;
          state_nxt = ST_LCG;
        end
      end
      ST_LCG: begin
        if (lcg_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (j_below) begin
            b_nxt     = quot[BUCKET_BITS-1:0];
            state_nxt = ST_LCG;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // hand over once the output register is free
        if (!ovalid_r || out_tready) begin
          ovalid_nxt  = 1'b1;
          obucket_nxt = b_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cfg_r    <= COUNT_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cfg_r    <= cfg_nxt;
      ovalid_r <= ovalid_nxt;
    end
    count_r   <= count_nxt;
    b_r       <= b_nxt;
    obucket_r <= obucket_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_W'(obucket_r);

  // The jump target always moves strictly upward while rounds continue
  a_j_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_done && j_below) |-> (quot > QW'(b_r)))
    else $error("jump target did not exceed current bucket");

  // The bucket being handed out lies below the latched count
  a_b_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> ((BUCKET_BITS+1)'(b_r) < count_r))
    else $error("bucket index not below bucket count");

  // The two shared units never finish in the same cycle
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(lcg_done && div_done))
    else $error("LCG and divider finished together");

  // An accepted key starts a round at once
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LCG))
    else $error("accepted key did not start a round");

endmodule

`default_nettype wire
